FILE: rtl/contraction_pulse_sequencer_assert.svh
// Assertion macros used by the sequencer top level.
// Both expect clk and rst_n in scope.
`ifndef CONTRACTION_PULSE_SEQUENCER_ASSERT_SVH
`define CONTRACTION_PULSE_SEQUENCER_ASSERT_SVH

// Same-cycle implication.
`define CPS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define CPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/cps_pkg.sv
`default_nettype none
package cps_pkg;

  localparam int TIME_W  = 23;
  localparam int STEP_W  = 10;
  localparam int LEVEL_W = 12;
  localparam int INT_W   = 16;
  localparam int TYPE_W  = 3;

  // register file contents
  typedef struct packed {
    logic [TIME_W-1:0] default_pulse_time;
    logic [TIME_W-1:0] gap_time;
    logic [TIME_W-1:0] short_pulse_time;
    logic [TIME_W-1:0] opening_time;
    logic [TIME_W-1:0] long_time_base;
    logic [STEP_W-1:0] level_step;
  } cfg_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;  // latch input transaction
    logic check;    // evaluate start / ignore
    logic load;     // load first phase of a new sequence
    logic step;     // advance one phase
    logic emit;     // load result registers
    logic dec;      // count down one tick
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic start_ok; // captured start command and sequencer idle
    logic busy;     // phase is not idle
    logic settled;  // idle, or current phase has time left
  } sts_t;

endpackage
`default_nettype wire

FILE: rtl/cps_regs.sv
`default_nettype none
module cps_regs
  import cps_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output cfg_t             cfg
);

  typedef enum logic [2:0] {
    REG_DEFAULT_PULSE = 3'd0,
    REG_GAP           = 3'd1,
    REG_SHORT_PULSE   = 3'd2,
    REG_OPENING       = 3'd3,
    REG_LONG_BASE     = 3'd4,
    REG_LEVEL_STEP    = 3'd5
  } reg_idx_t;

  cfg_t       cfg_r, cfg_nxt;
  logic [2:0] idx;
  logic       wr_en;

  assign pready = 1'b1;
  assign idx    = paddr[4:2];
  assign wr_en  = psel && penable && pwrite;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        REG_DEFAULT_PULSE: cfg_nxt.default_pulse_time = pwdata[TIME_W-1:0];
        REG_GAP:           cfg_nxt.gap_time           = pwdata[TIME_W-1:0];
        REG_SHORT_PULSE:   cfg_nxt.short_pulse_time   = pwdata[TIME_W-1:0];
        REG_OPENING:       cfg_nxt.opening_time       = pwdata[TIME_W-1:0];
        REG_LONG_BASE:     cfg_nxt.long_time_base     = pwdata[TIME_W-1:0];
        REG_LEVEL_STEP:    cfg_nxt.level_step         = pwdata[STEP_W-1:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_DEFAULT_PULSE: prdata = 32'(cfg_r.default_pulse_time);
      REG_GAP:           prdata = 32'(cfg_r.gap_time);
      REG_SHORT_PULSE:   prdata = 32'(cfg_r.short_pulse_time);
      REG_OPENING:       prdata = 32'(cfg_r.opening_time);
      REG_LONG_BASE:     prdata = 32'(cfg_r.long_time_base);
      REG_LEVEL_STEP:    prdata = 32'(cfg_r.level_step);
      default:           prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.default_pulse_time <= TIME_W'(200000);
      cfg_r.gap_time           <= TIME_W'(100000);
      cfg_r.short_pulse_time   <= TIME_W'(100000);
      cfg_r.opening_time       <= TIME_W'(1250000);
      cfg_r.long_time_base     <= TIME_W'(5000000);
      cfg_r.level_step         <= STEP_W'(250);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/cps_ctrl.sv
`default_nettype none
module cps_ctrl
  import cps_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  wire logic out_ready,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  typedef enum logic [6:0] {
    C_IDLE    = 7'b0000001,
    C_CHECK   = 7'b0000010,
    C_LOAD    = 7'b0000100,
    C_SETTLE1 = 7'b0001000,
    C_EMIT    = 7'b0010000,
    C_DEC     = 7'b0100000,
    C_SETTLE2 = 7'b1000000
  } ctrl_state_t;

  ctrl_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        slot_free;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == C_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      C_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = C_CHECK;
        end
      end
      C_CHECK: begin
        cmd.check = 1'b1;
        state_nxt = sts.start_ok ? C_LOAD : C_EMIT;
      end
      C_LOAD: begin
        cmd.load  = 1'b1;
        state_nxt = C_SETTLE1;
      end
      C_SETTLE1: begin
        if (sts.settled) begin
          state_nxt = C_EMIT;
        end else begin
          cmd.step = 1'b1;
        end
      end
      C_EMIT: begin
        if (slot_free) begin
          cmd.emit  = 1'b1;
          state_nxt = sts.busy ? C_DEC : C_IDLE;
        end
      end
      C_DEC: begin
        cmd.dec   = 1'b1;
        state_nxt = C_SETTLE2;
      end
      C_SETTLE2: begin
        if (sts.settled) begin
          state_nxt = C_IDLE;
        end else begin
          cmd.step = 1'b1;
        end
      end
      default: state_nxt = C_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    if (cmd.emit) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= C_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/cps_dp.sv
`default_nettype none
module cps_dp
  import cps_pkg::*;
#(
  parameter int COUNTER_BITS = 26
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire cfg_t               cfg,
  input  wire cmd_t               cmd,
  output sts_t                    sts,
  input  wire logic               in_operation,
  input  wire logic [TYPE_W-1:0]  in_contraction_type,
  input  wire logic               in_first_channel,
  input  wire logic [INT_W-1:0]   in_intensity,
  input  wire logic               in_opening,
  output logic [LEVEL_W-1:0]      out_level_first,
  output logic [LEVEL_W-1:0]      out_level_second,
  output logic                    out_busy_res,
  output logic                    out_start_ignored
);

  typedef enum logic [4:0] {
    PH_IDLE     = 5'b00001,
    PH_OPEN_ON  = 5'b00010,
    PH_OPEN_GAP = 5'b00100,
    PH_PULSE    = 5'b01000,
    PH_GAP      = 5'b10000
  } phase_t;

  localparam logic [TYPE_W-1:0] TY_SHORT  = 3'd0;
  localparam logic [TYPE_W-1:0] TY_LONG   = 3'd1;
  localparam logic [TYPE_W-1:0] TY_DOUBLE = 3'd2;
  localparam logic [TYPE_W-1:0] TY_TRIPLE = 3'd3;
  localparam logic [TYPE_W-1:0] TY_CO     = 3'd4;

  // x/3 == (x * ceil(2^25/3)) >> 25, exact for x < 2^23
  localparam int          DIV3_SHIFT = 25;
  localparam logic [23:0] DIV3_MUL   = 24'hAAAAAB;
  localparam int          PROD_W     = TIME_W + 24;

  localparam int GAP5_W = TIME_W + 3;
  localparam int SAT_W  = (COUNTER_BITS > GAP5_W) ? COUNTER_BITS : GAP5_W;
  localparam int UNIT_W = 3;

  // captured transaction
  logic              op_r;
  logic [TYPE_W-1:0] type_r;
  logic              first_r;
  logic [UNIT_W-1:0] units_r;
  logic              open_r;

  // sequence state
  phase_t                  phase_r, phase_nxt;
  logic [COUNTER_BITS-1:0] time_left_r, time_left_nxt;
  logic [1:0]              pulses_left_r, pulses_left_nxt;
  logic [TIME_W-1:0]       pulse_length_r, pulse_length_nxt;
  logic [LEVEL_W-1:0]      drive_level_r, drive_level_nxt;
  logic                    en_first_r, en_first_nxt;
  logic                    en_second_r, en_second_nxt;
  logic                    with_open_r, with_open_nxt;
  logic                    ignored_r;
  logic [TIME_W-1:0]       quot3_r;

  // result registers
  logic [LEVEL_W-1:0]      out_level_first_r;
  logic [LEVEL_W-1:0]      out_level_second_r;
  logic                    out_busy_r;
  logic                    out_ignored_r;

  logic [UNIT_W-1:0]       units_clamp;
  logic [UNIT_W-1:0]       units_eff;
  logic [PROD_W-1:0]       prod;
  logic [UNIT_W+STEP_W-1:0] level_prod;
  logic [TIME_W-1:0]       len_sel;
  logic [GAP5_W-1:0]       gap5;
  logic [SAT_W-1:0]        gap5_wide;
  logic [SAT_W-1:0]        cnt_max_wide;
  logic [COUNTER_BITS-1:0] gap5_fit;
  logic [COUNTER_BITS-1:0] gap_fit;
  logic [COUNTER_BITS-1:0] len_fit;
  logic [COUNTER_BITS-1:0] open_fit;
  logic                    phase_on;

  assign units_clamp = (in_intensity == '0) ? UNIT_W'(1) :
                       (in_intensity > INT_W'(4)) ? UNIT_W'(4) : in_intensity[UNIT_W-1:0];

  assign prod = PROD_W'(cfg.long_time_base) * PROD_W'(DIV3_MUL);

  assign gap5         = {3'b000, cfg.gap_time} + {1'b0, cfg.gap_time, 2'b00};
  assign gap5_wide    = SAT_W'(gap5);
  assign cnt_max_wide = SAT_W'({COUNTER_BITS{1'b1}});
  assign gap5_fit     = (gap5_wide > cnt_max_wide) ? {COUNTER_BITS{1'b1}}
                                                  : gap5_wide[COUNTER_BITS-1:0];
  assign gap_fit      = {{(COUNTER_BITS-TIME_W){1'b0}}, cfg.gap_time};
  assign open_fit     = {{(COUNTER_BITS-TIME_W){1'b0}}, cfg.opening_time};
  assign len_fit      = {{(COUNTER_BITS-TIME_W){1'b0}}, pulse_length_r};

  assign sts.busy     = (phase_r != PH_IDLE);
  assign sts.start_ok = op_r && (phase_r == PH_IDLE);
  assign sts.settled  = (phase_r == PH_IDLE) || (time_left_r != '0);

  assign phase_on = (phase_r == PH_OPEN_ON) || (phase_r == PH_PULSE);

  assign out_level_first   = out_level_first_r;
  assign out_level_second  = out_level_second_r;
  assign out_busy_res      = out_busy_r;
  assign out_start_ignored = out_ignored_r;

  // per-type setup
  always_comb begin
    en_first_nxt  = first_r;
    en_second_nxt = !first_r;
    pulses_left_nxt = 2'd1;
    units_eff     = units_r;
    with_open_nxt = 1'b0;
    case (type_r)
      TY_DOUBLE, TY_TRIPLE: begin
        pulses_left_nxt = (type_r == TY_DOUBLE) ? 2'd2 : 2'd3;
        en_first_nxt    = 1'b0;
        en_second_nxt   = 1'b1;
        units_eff       = UNIT_W'(4);
        with_open_nxt   = open_r;
      end
      TY_CO: begin
        en_first_nxt  = 1'b1;
        en_second_nxt = 1'b1;
        units_eff     = UNIT_W'(4);
      end
      default: ;
    endcase
  end

  assign level_prod      = (UNIT_W + STEP_W)'(units_eff) * (UNIT_W + STEP_W)'(cfg.level_step);
  assign drive_level_nxt = level_prod[LEVEL_W-1:0];

  // pulse length of a new sequence
  always_comb begin
    case (type_r)
      TY_SHORT, TY_CO: len_sel = cfg.short_pulse_time;
      TY_LONG: begin
        case (units_r)
          3'd2:    len_sel = cfg.long_time_base >> 1;
          3'd3:    len_sel = quot3_r;
          3'd4:    len_sel = cfg.long_time_base >> 2;
          default: len_sel = cfg.long_time_base;
        endcase
      end
      default: len_sel = cfg.default_pulse_time;
    endcase
  end

  always_comb begin
    phase_nxt        = phase_r;
    time_left_nxt    = time_left_r;
    pulse_length_nxt = pulse_length_r;
    if (cmd.load) begin
      pulse_length_nxt = len_sel;
      if (with_open_r) begin
        phase_nxt     = PH_OPEN_ON;
        time_left_nxt = open_fit;
      end else begin
        phase_nxt     = PH_PULSE;
        time_left_nxt = {{(COUNTER_BITS-TIME_W){1'b0}}, len_sel};
      end
    end else if (cmd.dec) begin
      time_left_nxt = time_left_r - COUNTER_BITS'(1);
    end else if (cmd.step) begin
      case (phase_r)
        PH_OPEN_ON: begin
          phase_nxt     = PH_OPEN_GAP;
          time_left_nxt = gap5_fit;
        end
        PH_OPEN_GAP, PH_GAP: begin
          phase_nxt     = PH_PULSE;
          time_left_nxt = len_fit;
        end
        PH_PULSE: begin
          if (pulses_left_r > 2'd1) begin
            phase_nxt     = PH_GAP;
            time_left_nxt = gap_fit;
          end else begin
            phase_nxt     = PH_IDLE;
            time_left_nxt = '0;
          end
        end
        default: begin
          phase_nxt     = PH_IDLE;
          time_left_nxt = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_IDLE;
      time_left_r    <= '0;
      pulses_left_r  <= '0;
      pulse_length_r <= '0;
      drive_level_r  <= '0;
      en_first_r     <= 1'b0;
      en_second_r    <= 1'b0;
      with_open_r    <= 1'b0;
      op_r           <= 1'b0;
      ignored_r      <= 1'b0;
    end else begin
      phase_r        <= phase_nxt;
      time_left_r    <= time_left_nxt;
      pulse_length_r <= pulse_length_nxt;
      if (cmd.capture) op_r <= in_operation;
      if (cmd.check) ignored_r <= op_r && sts.busy;
      if (cmd.check && sts.start_ok) begin
        en_first_r    <= en_first_nxt;
        en_second_r   <= en_second_nxt;
        pulses_left_r <= pulses_left_nxt;
        drive_level_r <= drive_level_nxt;
        with_open_r   <= with_open_nxt;
      end else if (cmd.step && phase_r == PH_PULSE) begin
        pulses_left_r <= (pulses_left_r > 2'd1) ? pulses_left_r - 2'd1 : 2'd0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      type_r  <= in_contraction_type;
      first_r <= in_first_channel;
      units_r <= units_clamp;
      open_r  <= in_opening;
    end
    if (cmd.check) quot3_r <= TIME_W'(prod[PROD_W-1:DIV3_SHIFT]);
    if (cmd.emit) begin
      out_level_first_r  <= (phase_on && en_first_r) ? drive_level_r : '0;
      out_level_second_r <= (phase_on && en_second_r) ? drive_level_r : '0;
      out_busy_r         <= sts.busy;
      out_ignored_r      <= ignored_r;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/contraction_pulse_sequencer.sv
// Flow: a plain tick is captured, checked and emitted, with a countdown step when a
//   sequence runs; a start adds a load and a pass that skips zero-length phases.
// Input: one transaction at a time, in_ready only while the controller is idle;
//   the phase-step sequencer advances one phase per cycle.
// Reset: synchronous active-low rst_n, no clearing pass; control registers return to
//   defaults, the sequencer to idle; payload and result registers are not reset.
`default_nettype none
module contraction_pulse_sequencer
  import cps_pkg::*;
#(
  parameter int COUNTER_BITS = 26
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // input transaction: one microsecond tick, optionally with a start command
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               in_operation,
  input  wire logic [TYPE_W-1:0]  in_contraction_type,
  input  wire logic               in_first_channel,
  input  wire logic [INT_W-1:0]   in_intensity,
  input  wire logic               in_opening,
  // result transaction: DAC levels and status for that tick
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [LEVEL_W-1:0]      out_level_first,
  output logic [LEVEL_W-1:0]      out_level_second,
  output logic                    out_busy_res,
  output logic                    out_start_ignored,
  // APB register port
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [4:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

`include "contraction_pulse_sequencer_assert.svh"

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  // Timing register file (pulse, gap, opening, long base, level step).
  cps_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Controller: accept, start check, phase settling, result emit, countdown.
  cps_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Datapath: phase register, countdown, long-pulse divide, level multiply.
  cps_dp #(
    .COUNTER_BITS (COUNTER_BITS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg                 (cfg),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_operation        (in_operation),
    .in_contraction_type (in_contraction_type),
    .in_first_channel    (in_first_channel),
    .in_intensity        (in_intensity),
    .in_opening          (in_opening),
    .out_level_first     (out_level_first),
    .out_level_second    (out_level_second),
    .out_busy_res        (out_busy_res),
    .out_start_ignored   (out_start_ignored)
  );

  // Ready only once zero-length phases have been skipped.
  `CPS_ASSERT_NOW(a_ready_settled, in_ready, sts.settled, "ready with unsettled phase")
  // An idle result drives no level.
  `CPS_ASSERT_NOW(a_idle_quiet, out_valid && !out_busy_res,
    out_level_first == '0 && out_level_second == '0, "level driven while idle")
  // A dropped start implies a sequence is running.
  `CPS_ASSERT_NOW(a_ignore_busy, out_valid && out_start_ignored, out_busy_res,
    "start ignored while idle")
  // An accepted transaction leaves the controller not ready in the next cycle.
  `CPS_ASSERT_NEXT(a_accept_busy, in_valid && in_ready, !in_ready,
    "ready right after accept")

endmodule
`default_nettype wire

FILE: tb/testbench.sv
`timescale 1ns / 1ps

localparam int CNT_W = 26;

localparam logic OP_TICK  = 1'b0;
localparam logic OP_START = 1'b1;

localparam logic [2:0] CT_SHORT  = 3'd0;
localparam logic [2:0] CT_LONG   = 3'd1;
localparam logic [2:0] CT_DOUBLE = 3'd2;
localparam logic [2:0] CT_TRIPLE = 3'd3;
localparam logic [2:0] CT_COCON  = 3'd4;
localparam logic [2:0] CT_RSVD5  = 3'd5;
localparam logic [2:0] CT_RSVD6  = 3'd6;
localparam logic [2:0] CT_RSVD7  = 3'd7;

localparam logic [4:0] REG_DEFAULT_PULSE = 5'd0;
localparam logic [4:0] REG_GAP           = 5'd4;
localparam logic [4:0] REG_SHORT_PULSE   = 5'd8;
localparam logic [4:0] REG_OPENING       = 5'd12;
localparam logic [4:0] REG_LONG_BASE     = 5'd16;
localparam logic [4:0] REG_LEVEL_STEP    = 5'd20;

typedef enum logic [2:0] {
  SEQ_IDLE, SEQ_OPEN_ON, SEQ_OPEN_GAP, SEQ_PULSE, SEQ_GAP
} seq_phase_t;

typedef struct packed {
  logic        op;
  logic [2:0]  ctype;
  logic        first;
  logic [15:0] inten;
  logic        open;
} tick_t;

typedef struct packed {
  logic [11:0] lvl_first;
  logic [11:0] lvl_second;
  logic        busy;
  logic        ignored;
} dac_out_t;

class dac_scoreboard;
  int errors;
  dac_out_t levels_q[$];

  logic [22:0] default_pulse, gap, short_pulse, opening_len, long_base;
  logic [9:0]  step;

  seq_phase_t        phase;
  logic [CNT_W-1:0]  time_left;
  logic [1:0]        pulses_left;
  logic [22:0]       pulse_len;
  logic [11:0]       level;
  logic              en_first, en_second;

  function new();
    errors        = 0;
    default_pulse = 23'd200000;
    gap           = 23'd100000;
    short_pulse   = 23'd100000;
    opening_len   = 23'd1250000;
    long_base     = 23'd5000000;
    step          = 10'd250;
    phase         = SEQ_IDLE;
    time_left     = '0;
    pulses_left   = '0;
    pulse_len     = '0;
    level         = '0;
    en_first      = 1'b0;
    en_second     = 1'b0;
  endfunction

  function void write_reg(logic [4:0] addr, logic [31:0] data);
    case (addr)
      REG_DEFAULT_PULSE: default_pulse = data[22:0];
      REG_GAP:           gap = data[22:0];
      REG_SHORT_PULSE:   short_pulse = data[22:0];
      REG_OPENING:       opening_len = data[22:0];
      REG_LONG_BASE:     long_base = data[22:0];
      REG_LEVEL_STEP:    step = data[9:0];
      default: ;
    endcase
  endfunction

  function bit running();
    return phase != SEQ_IDLE;
  endfunction

  function int pending();
    return levels_q.size();
  endfunction

  // saturate to the phase counter width
  function logic [CNT_W-1:0] fit(logic [63:0] v);
    logic [63:0] top;
    top = (64'd1 << CNT_W) - 64'd1;
    return (v > top) ? top[CNT_W-1:0] : v[CNT_W-1:0];
  endfunction

  function void enter(seq_phase_t p);
    phase = p;
    case (p)
      SEQ_OPEN_ON:  time_left = fit(64'(opening_len));
      SEQ_OPEN_GAP: time_left = fit(64'(gap) * 64'd5);
      SEQ_PULSE:    time_left = fit(64'(pulse_len));
      SEQ_GAP:      time_left = fit(64'(gap));
      default: begin
        phase     = SEQ_IDLE;
        time_left = '0;
      end
    endcase
  endfunction

  function void advance();
    case (phase)
      SEQ_OPEN_ON:           enter(SEQ_OPEN_GAP);
      SEQ_OPEN_GAP, SEQ_GAP: enter(SEQ_PULSE);
      SEQ_PULSE: begin
        if (pulses_left > 2'd1) begin
          pulses_left--;
          enter(SEQ_GAP);
        end else begin
          pulses_left = '0;
          enter(SEQ_IDLE);
        end
      end
      default: enter(SEQ_IDLE);
    endcase
  endfunction

  // skip phases of zero length
  function void settle();
    while (phase != SEQ_IDLE && time_left == '0) advance();
  endfunction

  function void load_sequence(tick_t t);
    int   units;
    logic with_open;
    units     = (t.inten > 16'd4) ? 4 : ((t.inten < 16'd1) ? 1 : int'(t.inten));
    with_open = 1'b0;
    en_first    = t.first;
    en_second   = !t.first;
    pulses_left = 2'd1;
    pulse_len   = default_pulse;
    case (t.ctype)
      CT_SHORT: pulse_len = short_pulse;
      CT_LONG:  pulse_len = 23'(long_base / units);
      CT_DOUBLE, CT_TRIPLE: begin
        pulses_left = (t.ctype == CT_DOUBLE) ? 2'd2 : 2'd3;
        en_first    = 1'b0;
        en_second   = 1'b1;
        units       = 4;
        with_open   = t.open;
      end
      CT_COCON: begin
        pulse_len = short_pulse;
        en_first  = 1'b1;
        en_second = 1'b1;
        units     = 4;
      end
      default: ;
    endcase
    level = 12'(units * step);
    enter(with_open ? SEQ_OPEN_ON : SEQ_PULSE);
    settle();
  endfunction

  function void note_tick(tick_t t);
    dac_out_t e;
    logic     on;
    e.ignored = 1'b0;
    if (t.op == OP_START) begin
      if (phase != SEQ_IDLE) e.ignored = 1'b1;
      else load_sequence(t);
    end
    on           = (phase == SEQ_OPEN_ON || phase == SEQ_PULSE);
    e.lvl_first  = (on && en_first) ? level : '0;
    e.lvl_second = (on && en_second) ? level : '0;
    e.busy       = (phase != SEQ_IDLE);
    if (phase != SEQ_IDLE) begin
      time_left--;
      settle();
    end
    levels_q.push_back(e);
  endfunction

  task report(string msg);
    errors++;
    if (errors <= 50) $display("MISMATCH @%0t: %s", $realtime, msg);
  endtask

  task check_levels(dac_out_t got);
    dac_out_t want;
    if (levels_q.size() == 0) begin
      report("result transaction with no tick pending");
      return;
    end
    want = levels_q.pop_front();
    if (got.lvl_first != want.lvl_first)
      report($sformatf("level_first got %0d want %0d", got.lvl_first, want.lvl_first));
    if (got.lvl_second != want.lvl_second)
      report($sformatf("level_second got %0d want %0d", got.lvl_second, want.lvl_second));
    if (got.busy != want.busy)
      report($sformatf("busy_res got %0b want %0b", got.busy, want.busy));
    if (got.ignored != want.ignored)
      report($sformatf("start_ignored got %0b want %0b", got.ignored, want.ignored));
  endtask

  task check_drained();
    while (levels_q.size() != 0) begin
      void'(levels_q.pop_front());
      report("tick result never arrived");
    end
  endtask
endclass

module testbench;
  localparam int HOLD_CYCLES  = 300;  // long receiver back-pressure
  localparam int DRAIN_CYCLES = 16;   // covers the worst start latency

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;

  // input channel
  logic        in_valid = 1'b0;
  wire         in_ready;
  logic        in_operation = 1'b0;
  logic [2:0]  in_contraction_type = '0;
  logic        in_first_channel = 1'b0;
  logic [15:0] in_intensity = '0;
  logic        in_opening = 1'b0;

  // result channel
  wire         out_valid;
  logic        out_ready = 1'b0;
  wire [11:0]  out_level_first;
  wire [11:0]  out_level_second;
  wire         out_busy_res;
  wire         out_start_ignored;

  // register port
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  wire [31:0]  prdata;
  wire         pready;

  // traffic knobs, percent of cycles
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  // hold-off handshake between the stimulus and the receiver process
  int hold_requests = 0;
  int hold_seen     = 0;
  int hold_left     = 0;

  dac_scoreboard sb;

  contraction_pulse_sequencer i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_operation      (in_operation),
    .in_contraction_type(in_contraction_type),
    .in_first_channel  (in_first_channel),
    .in_intensity      (in_intensity),
    .in_opening        (in_opening),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_level_first   (out_level_first),
    .out_level_second  (out_level_second),
    .out_busy_res      (out_busy_res),
    .out_start_ignored (out_start_ignored),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  always #4 clk = ~clk;

  // Receiver: checks each result transaction on the edge where it completes,
  // using the values from before the edge, then picks out_ready for the next
  // cycle. A hold request forces a long stall so the block backs up.
  always @(posedge clk) begin : rx
    dac_out_t got;
    if (out_valid && out_ready) begin
      got.lvl_first  = out_level_first;
      got.lvl_second = out_level_second;
      got.busy       = out_busy_res;
      got.ignored    = out_start_ignored;
      sb.check_levels(got);
    end
    if (hold_seen != hold_requests) begin
      hold_seen <= hold_requests;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic tick_t make_tick(logic op, logic [2:0] ctype, logic first,
                                      logic [15:0] inten, logic open);
    tick_t t;
    t.op    = op;
    t.ctype = ctype;
    t.first = first;
    t.inten = inten;
    t.open  = open;
    return t;
  endfunction

  // Mostly small intensities so the clamp edges get hit; sometimes the full
  // 16-bit range so every bit toggles.
  function automatic tick_t random_tick();
    tick_t t;
    t.op    = ($urandom_range(99) < 20) ? OP_START : OP_TICK;
    t.ctype = 3'($urandom_range(7));
    t.first = 1'($urandom_range(1));
    t.inten = ($urandom_range(9) < 8) ? 16'($urandom_range(6)) : 16'($urandom);
    t.open  = 1'($urandom_range(1));
    return t;
  endfunction

  // Offers one tick. Entered at a clock edge; returns at the edge where the
  // transaction completed, with valid still high so the next tick can follow
  // back to back.
  task automatic send_tick(input tick_t t);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid            <= 1'b1;
    in_operation        <= t.op;
    in_contraction_type <= t.ctype;
    in_first_channel    <= t.first;
    in_intensity        <= t.inten;
    in_opening          <= t.open;
    do @(posedge clk); while (!in_ready);
    sb.note_tick(t);
  endtask

  // Run the current sequence out with plain ticks, then wait for every
  // result, so the block is idle before a register write.
  task automatic quiesce();
    while (sb.running()) send_tick(make_tick(OP_TICK, 3'($urandom_range(7)),
        1'($urandom_range(1)), 16'($urandom), 1'($urandom_range(1))));
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // setup cycle, access cycle, then one cycle with the bus released
  task automatic cfg_write(input logic [4:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.write_reg(addr, data);
    @(posedge clk);
  endtask

  task automatic cfg_all(input int dflt, input int gp, input int shrt, input int opn,
                         input int lbase, input int lstep);
    cfg_write(REG_DEFAULT_PULSE, dflt);
    cfg_write(REG_GAP, gp);
    cfg_write(REG_SHORT_PULSE, shrt);
    cfg_write(REG_OPENING, opn);
    cfg_write(REG_LONG_BASE, lbase);
    cfg_write(REG_LEVEL_STEP, lstep);
  endtask

  initial begin : main
    int seg;
    int r;
    int lstep;
    sb = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset defaults: a start would run for hundreds of thousands of ticks,
    // so only plain ticks here, with junk in the ignored fields.
    send_tick(make_tick(OP_TICK, CT_RSVD7, 1'b1, 16'hFFFF, 1'b1));
    send_tick(make_tick(OP_TICK, CT_SHORT, 1'b0, 16'h0000, 1'b0));
    quiesce();

    // All times zero: every sequence ends on its own start tick, not busy.
    cfg_all(0, 0, 0, 0, 0, 1023);
    send_tick(make_tick(OP_START, CT_SHORT, 1'b0, 16'd0, 1'b0));
    send_tick(make_tick(OP_START, CT_COCON, 1'b1, 16'hFFFF, 1'b1));
    send_tick(make_tick(OP_START, CT_TRIPLE, 1'b0, 16'd3, 1'b1));
    send_tick(make_tick(OP_START, CT_LONG, 1'b1, 16'd2, 1'b0));
    send_tick(make_tick(OP_START, CT_RSVD5, 1'b1, 16'd1, 1'b0));
    quiesce();

    // Short times. Zero gap: the opening gap is skipped and pulses run back
    // to back. Starts while running are dropped and flagged.
    cfg_all(2, 0, 1, 1, 7, 1023);
    send_tick(make_tick(OP_START, CT_DOUBLE, 1'b1, 16'd1, 1'b1));
    send_tick(make_tick(OP_START, CT_LONG, 1'b1, 16'd4, 1'b0));
    quiesce();
    send_tick(make_tick(OP_START, CT_LONG, 1'b1, 16'd3, 1'b0));   // 7/3 ticks
    send_tick(make_tick(OP_START, CT_SHORT, 1'b0, 16'hFFFF, 1'b0));
    quiesce();
    send_tick(make_tick(OP_START, CT_RSVD7, 1'b0, 16'd0, 1'b1));
    quiesce();

    // Upper extremes on the registers that these types never touch.
    cfg_all(1, 8388607, 1, 8388607, 8388607, 1023);
    send_tick(make_tick(OP_START, CT_SHORT, 1'b1, 16'd4, 1'b1));
    send_tick(make_tick(OP_START, CT_COCON, 1'b0, 16'd1, 1'b1));
    send_tick(make_tick(OP_START, CT_RSVD6, 1'b1, 16'd2, 1'b0));
    quiesce();

    // Random part: small random times so sequences stay short, four traffic
    // patterns, two register settings each.
    for (seg = 0; seg < 8; seg++) begin
      case (seg % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 69; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 69; end
        default: begin send_idle_pct = 27; recv_stall_pct = 27; end
      endcase
      r = $urandom_range(7);
      lstep = (r == 0) ? 0 : ((r == 1) ? 1023 : $urandom_range(1023));
      cfg_all($urandom_range(6), $urandom_range(4), $urandom_range(6),
              $urandom_range(6), $urandom_range(30), lstep);
      // back-pressure: receiver stalls long while ticks keep coming
      if (seg == 0) hold_requests <= hold_requests + 1;
      repeat (88) send_tick(random_tick());
      quiesce();
    end

    sb.check_drained();
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin : watchdog
    #5000000;
    $display("== FAIL ==");
    $finish;
  end
endmodule
